// ===== src/led_matrix_draw_engine_assert.svh =====
// Assertion macros for the LED matrix draw engine.
// Used by lmd_front and lmd_back; no other dependency.
`ifndef LED_MATRIX_DRAW_ENGINE_ASSERT_SVH
`define LED_MATRIX_DRAW_ENGINE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LMD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmd assertion failed");
// implication checked in the next cycle
`define LMD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lmd assertion failed");
`endif

// ===== src/lmd_pkg.sv =====
// Shared types and constants for the LED matrix draw engine.
// No dependencies.
package lmd_pkg;
	localparam int MAX_DIM_DEF = 16;
	localparam int CMD_W = 3;
	localparam int IN_W = 72;
	localparam int OUT_W = 40;

	typedef enum logic [2:0] {
		CMD_DOT = 3'd0, CMD_OUTLINE = 3'd1, CMD_FILL = 3'd2,
		CMD_GLOW = 3'd3, CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SQRT, ST_WRITE, ST_READ, ST_DONE
	} st_t;

	typedef enum logic [2:0] {
		CL_IDLE, CL_CLEAR
	} cl_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic signed [5:0] pos_x;
		logic signed [5:0] pos_y;
		logic [3:0]        frac_x;
		logic [3:0]        frac_y;
		logic [4:0]        rect_w;
		logic [4:0]        rect_h;
		logic [3:0]        radius;
		logic [7:0]        falloff;
		logic [7:0]        hue;
		logic [7:0]        sat;
		logic [7:0]        val;
	} item_t;

	typedef struct packed {
		logic [7:0] led_index;
		logic [7:0] hue_out;
		logic [7:0] sat_out;
		logic [7:0] val_out;
		logic       in_range;
	} res_t;

	localparam logic [0:0] ADDR_WIDTH_REG = 1'b0;
	localparam logic [0:0] ADDR_HEIGHT_REG = 1'b1;
endpackage

// ===== src/lmd_front.sv =====
// Front end: accepts command transfers, unpacks them into a two-entry queue.
// Depends on lmd_pkg.
module lmd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [lmd_pkg::IN_W-1:0]  s_tdata,
	output logic                      q_valid,
	input  logic                      q_pop,
	output lmd_pkg::item_t            q_item
);
	import lmd_pkg::*;
	item_t mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	item_t unp;
	logic push;

	assign unp.cmd     = s_tdata[2:0];
	assign unp.pos_x   = s_tdata[8:3];
	assign unp.pos_y   = s_tdata[14:9];
	assign unp.frac_x  = s_tdata[18:15];
	assign unp.frac_y  = s_tdata[22:19];
	assign unp.rect_w  = s_tdata[27:23];
	assign unp.rect_h  = s_tdata[32:28];
	assign unp.radius  = s_tdata[36:33];
	assign unp.falloff = s_tdata[44:37];
	assign unp.hue     = s_tdata[52:45];
	assign unp.sat     = s_tdata[60:53];
	assign unp.val     = s_tdata[68:61];

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= unp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	`include "led_matrix_draw_engine_assert.svh"
	`LMD_ASSERT_IMP(a_no_pop_empty, q_pop, cnt_q != 2'd0)
	`LMD_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 2'd2)
	`LMD_ASSERT_NEXT(a_push_only, push && !q_pop && cnt_q == 2'd0, cnt_q == 2'd1)
endmodule

// ===== src/lmd_back.sv =====
// Back end: walks each draw command's pixel box, computes glow values with a
// bit-serial square root, and owns the frame store. Depends on lmd_pkg.
module lmd_back #(
	parameter int MAX_DIM = lmd_pkg::MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  lmd_pkg::item_t       q_item,
	input  logic [4:0]           grid_width,
	input  logic [4:0]           grid_height,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output lmd_pkg::res_t        m_res
);
	import lmd_pkg::*;
	localparam int AW = $clog2(MAX_DIM);
	localparam int DEPTH = 1 << (2 * AW);
	localparam int CW = 8;

	st_t st_q, st_nx;
	item_t it_q;
	logic signed [CW-1:0] i_q, j_q, i0_q, i1_q, j0_q, j1_q;
	logic [23:0] mem [DEPTH];
	logic [23:0] rd_q;
	logic clr_q;
	logic [2*AW-1:0] clr_a_q;
	logic [2*AW:0] clr_cnt_q;
	logic out_v_q;
	res_t out_q;

	// sqrt unit
	logic [21:0] sq_n_q, sq_r_q, sq_b_q;
	logic [21:0] sq_t;
	logic signed [CW+4:0] cx, cy, dxs, dys;
	logic [21:0] d2;

	logic [5:0] ew, eh;
	always_comb begin
		ew = (grid_width > 5'(MAX_DIM > 31 ? 31 : MAX_DIM)) ?
			6'(MAX_DIM > 31 ? 31 : MAX_DIM) : {1'b0, grid_width};
		eh = (grid_height > 5'(MAX_DIM > 31 ? 31 : MAX_DIM)) ?
			6'(MAX_DIM > 31 ? 31 : MAX_DIM) : {1'b0, grid_height};
	end

	function automatic logic ins(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
		logic [5:0] w, logic [5:0] h);
		ins = (x >= 0) && (y >= 0) && (x < $signed({2'b0, w})) && (y < $signed({2'b0, h}));
	endfunction

	logic busy_out;
	assign busy_out = out_v_q;
	assign m_tvalid = out_v_q;
	assign m_res = out_q;

	// glow centre
	assign cx = 13'($signed({{(CW-1){it_q.pos_x[5]}}, it_q.pos_x}) * 16
		+ $signed({9'b0, it_q.frac_x}));
	assign cy = 13'($signed({{(CW-1){it_q.pos_y[5]}}, it_q.pos_y}) * 16
		+ $signed({9'b0, it_q.frac_y}));
	assign dxs = 13'(cx - 13'(i_q) * 16);
	assign dys = 13'(cy - 13'(j_q) * 16);
	// squares need full width: |d| reaches 255 sixteenths
	assign d2 = 22'(32'(dxs) * 32'(dxs)) + 22'(32'(dys) * 32'(dys));
	assign sq_t = sq_r_q + sq_b_q;

	// box limits for next command
	logic signed [CW-1:0] px, py, nw, nh, nr, ncx0, ncx1, ncy0, ncy1;
	logic signed [CW+4:0] gcx, gcy;
	always_comb begin
		px = CW'(q_item.pos_x); py = CW'(q_item.pos_y);
		nw = CW'({1'b0, q_item.rect_w}); nh = CW'({1'b0, q_item.rect_h});
		nr = CW'({1'b0, q_item.radius});
		gcx = 13'($signed({{7{q_item.pos_x[5]}}, q_item.pos_x}) * 16
			+ 13'(q_item.frac_x));
		gcy = 13'($signed({{7{q_item.pos_y[5]}}, q_item.pos_y}) * 16
			+ 13'(q_item.frac_y));
		ncx0 = CW'((gcx - 13'(nr) * 16) / 16);
		ncy0 = CW'((gcy - 13'(nr) * 16) / 16);
		ncx1 = CW'((gcx + 13'sd15) >>> 4) + nr;
		ncy1 = CW'((gcy + 13'sd15) >>> 4) + nr;
	end

	// does current (i,j) belong to the shape
	logic hit, last_pt;
	always_comb begin
		hit = 1'b0;
		case (it_q.cmd) inside
			CMD_DOT, CMD_FILL: hit = 1'b1;
			CMD_OUTLINE: hit = (j_q == j0_q && i_q != i1_q) ||
				(j_q == j1_q && i_q != i1_q) || i_q == i0_q || i_q == i1_q;
			default: hit = 1'b1;
		endcase
		last_pt = (i_q == i1_q) && (j_q == j1_q);
	end

	logic empty_box;
	always_comb begin
		case (q_item.cmd) inside
			CMD_FILL: empty_box = (q_item.rect_w == 0) || (q_item.rect_h == 0);
			CMD_DOT, CMD_OUTLINE, CMD_GLOW: empty_box = 1'b0;
			default: empty_box = 1'b1;
		endcase
	end

	logic start;
	assign start = (st_q == ST_IDLE) && q_valid && !clr_q && !busy_out;
	assign q_pop = start;

	// glow value
	logic signed [20:0] e_val;
	logic [7:0] gv;
	always_comb begin
		e_val = $signed({9'b0, it_q.val, 4'b0})
			- $signed(21'(sq_r_q[11:0]) * 21'(it_q.falloff));
		if (e_val < 0) gv = '0;
		else if (e_val[20:4] > 255) gv = 8'hFF;
		else gv = e_val[11:4];
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: if (start) begin
				if (q_item.cmd == CMD_READ) st_nx = ST_READ;
				else if (empty_box) st_nx = ST_DONE;
				else if (q_item.cmd == CMD_GLOW) st_nx = ST_SQRT;
				else st_nx = ST_SCAN;
			end
			ST_SCAN: if (last_pt) st_nx = ST_DONE;
			ST_SQRT: if (sq_b_q == 0) st_nx = ST_WRITE;
			ST_WRITE: st_nx = last_pt ? ST_DONE : ST_SQRT;
			ST_READ: st_nx = ST_DONE;
			ST_DONE: st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	logic wr_en;
	logic [23:0] wr_d;
	logic [2*AW-1:0] wr_a;
	always_comb begin
		wr_en = 1'b0; wr_d = {it_q.hue, it_q.sat, it_q.val};
		wr_a = {i_q[AW-1:0], j_q[AW-1:0]};
		if (clr_q) begin
			wr_en = 1'b1; wr_d = '0; wr_a = clr_a_q;
		end else if (st_q == ST_SCAN) begin
			wr_en = hit && ins(i_q, j_q, ew, eh);
		end else if (st_q == ST_WRITE) begin
			wr_en = ins(i_q, j_q, ew, eh);
			wr_d = {it_q.hue, it_q.sat, gv};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_a] <= wr_d;
		rd_q <= mem[{i_q[AW-1:0], j_q[AW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			it_q <= q_item;
			case (q_item.cmd)
				CMD_GLOW: begin
					i0_q <= ncx0; i1_q <= ncx1; j0_q <= ncy0; j1_q <= ncy1;
					i_q <= ncx0; j_q <= ncy0;
				end
				CMD_OUTLINE: begin
					i0_q <= px; i1_q <= px + nw; j0_q <= py; j1_q <= py + nh;
					i_q <= px; j_q <= py;
				end
				CMD_FILL: begin
					i0_q <= px; i1_q <= px + nw - CW'(1); j0_q <= py;
					j1_q <= py + nh - CW'(1);
					i_q <= px; j_q <= py;
				end
				default: begin
					i0_q <= px; i1_q <= px; j0_q <= py; j1_q <= py;
					i_q <= px; j_q <= py;
				end
			endcase
			sq_r_q <= '0; sq_b_q <= 22'h100000;
		end else if ((st_q == ST_SCAN) || (st_q == ST_WRITE)) begin
			if (j_q == j1_q) begin
				j_q <= j0_q; i_q <= i_q + CW'(1);
			end else j_q <= j_q + CW'(1);
			sq_r_q <= '0; sq_b_q <= 22'h100000;
		end else if (st_q == ST_SQRT) begin
			if (sq_b_q == 22'h100000) begin
				if (d2 >= sq_t) begin
					sq_n_q <= d2 - sq_t; sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_n_q <= d2; sq_r_q <= sq_r_q >> 1;
				end
			end else if (sq_b_q != 0) begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t; sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else sq_r_q <= sq_r_q >> 1;
			end
			if (sq_b_q != 0) sq_b_q <= sq_b_q >> 2;
		end
		// read data is registered at the end of ST_READ, used in ST_DONE
		if (st_q == ST_DONE) begin
			if (it_q.cmd == CMD_READ) begin
				out_q.in_range <= ins(i_q, j_q, ew, eh);
				if (ins(i_q, j_q, ew, eh)) begin
					out_q.led_index <= j_q[0] ? 8'(i_q + j_q * CW'(eh))
						: 8'(CW'(eh) - 1 - i_q + j_q * CW'(eh));
					{out_q.hue_out, out_q.sat_out, out_q.val_out} <= rd_q;
				end else begin
					out_q.led_index <= '0; out_q.hue_out <= '0;
					out_q.sat_out <= '0; out_q.val_out <= '0;
				end
			end else begin
				out_q <= '{led_index: 8'd0, hue_out: 8'd0, sat_out: 8'd0,
					val_out: 8'd0, in_range: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_v_q <= 1'b0;
			clr_q <= 1'b1; clr_a_q <= '0; clr_cnt_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == ST_DONE) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (clr_q) begin
				clr_a_q <= clr_a_q + 1'b1;
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (2*AW+1)'(DEPTH - 1)) clr_q <= 1'b0;
			end
		end
	end

	`include "led_matrix_draw_engine_assert.svh"
	`LMD_ASSERT_IMP(a_no_start_clear, clr_q, !q_pop)
	`LMD_ASSERT_NEXT(a_done_valid, st_q == ST_DONE, m_tvalid)
	`LMD_ASSERT_IMP(a_idle_no_sqrt, st_q == ST_IDLE, !(wr_en && !clr_q))
endmodule

// ===== src/led_matrix_draw_engine.sv =====
// LED matrix draw engine: HSV frame store with draw and read-back commands.
// Each command gives one result: dot writes one pixel and read fetches one;
// rectangles visit each box pixel in turn; glow runs an 11-step square root
// and a write for each pixel of its box (at most (2r+2)^2 pixels).
// One command at a time in the back end; a two-entry queue absorbs the next.
// Reset (arst_n low) clears control; afterwards all 4^ceil(log2(MAX_DIM))
// store entries (256 by default) are cleared, and no command starts until then.
module led_matrix_draw_engine #(
	parameter int MAX_DIM = lmd_pkg::MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// cmd, pos_x, pos_y, frac_x, frac_y, rect_w, rect_h, radius, falloff,
	// hue, sat, val (lowest first), zero padded
	input  logic [lmd_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// led_index, hue_out, sat_out, val_out, in_range (lowest first)
	output logic [lmd_pkg::OUT_W-1:0] m_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import lmd_pkg::*;
	logic [4:0] gw_q, gh_q;
	logic q_valid, q_pop;
	item_t q_item;
	res_t res;

	assign pready = 1'b1;
	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 5'd16; gh_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr == {ADDR_WIDTH_REG, 2'b00}) gw_q <= pwdata[4:0];
			else if (paddr == {ADDR_HEIGHT_REG, 2'b00}) gh_q <= pwdata[4:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == {ADDR_WIDTH_REG, 2'b00}) prdata = {27'b0, gw_q};
		else if (paddr == {ADDR_HEIGHT_REG, 2'b00}) prdata = {27'b0, gh_q};
	end

	lmd_front u_front (.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_pop, .q_item);

	lmd_back #(.MAX_DIM(MAX_DIM)) u_back (.clk, .arst_n, .q_valid, .q_pop,
		.q_item, .grid_width(gw_q), .grid_height(gh_q), .m_tvalid, .m_tready,
		.m_res(res));

	assign m_tdata = {7'b0, res.in_range, res.val_out, res.sat_out, res.hue_out,
		res.led_index};
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for led_matrix_draw_engine: directed and random commands,
// with a frame store predictor inside; depends on lmd_pkg and the RTL.
module tb_top;
	import lmd_pkg::*;

	localparam int DIM = 16;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int RAND_ITEMS = 1500;
	// command codes with no meaning in the block; they must draw nothing
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [2:0] REG_ADDR_WIDTH = 3'd0;
	localparam logic [2:0] REG_ADDR_HEIGHT = 3'd4;

	typedef struct {
		logic [2:0] cmd;
		logic [5:0] pos_x;
		logic [5:0] pos_y;
		logic [3:0] frac_x;
		logic [3:0] frac_y;
		logic [4:0] rect_w;
		logic [4:0] rect_h;
		logic [3:0] radius;
		logic [7:0] falloff;
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] led_index;
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic       in_range;
	} pixel_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	led_matrix_draw_engine dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: shadow frame store and grid registers
	logic [23:0] shadow_px [DIM][DIM];
	int          grid_w_reg;
	int          grid_h_reg;

	draw_cmd_t   cmd_q[$];      // commands waiting for the driver
	pixel_resp_t resp_q[$];     // predicted responses, oldest first
	draw_cmd_t   cmd_on_bus;    // command currently offered on s_tdata
	logic        cmd_took;      // transfer seen at the last rising edge
	int          src_idle_pct;
	int          snk_idle_pct;
	int          errors;
	int          cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [71:0] pack_cmd(draw_cmd_t c);
		return {3'b0, c.val, c.sat, c.hue, c.falloff, c.radius, c.rect_h, c.rect_w,
			c.frac_y, c.frac_x, c.pos_y, c.pos_x, c.cmd};
	endfunction

	function automatic int eff_w();
		return grid_w_reg > DIM ? DIM : grid_w_reg;
	endfunction

	function automatic int eff_h();
		return grid_h_reg > DIM ? DIM : grid_h_reg;
	endfunction

	function automatic bit on_grid(int x, int y);
		return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
	endfunction

	function automatic void put_pixel(int x, int y, logic [23:0] hsv);
		if (on_grid(x, y))
			shadow_px[x][y] = hsv;
	endfunction

	// bitwise integer square root, floor
	function automatic int unsigned int_sqrt(int unsigned n);
		int unsigned root;
		int unsigned bitv;
		root = 0;
		bitv = 32'h4000_0000;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// centre in sixteenths; box from trunc((c-16r)/16) to ceil(c/16)+r
	function automatic void draw_glow(int cx, int cy, int r, int fall,
			logic [7:0] hue, logic [7:0] sat, int peak);
		int x0, y0, x1, y1, dx, dy, e, v;
		int unsigned d;
		x0 = (cx - 16 * r) / 16;
		y0 = (cy - 16 * r) / 16;
		x1 = ((cx + 15) >>> 4) + r;
		y1 = ((cy + 15) >>> 4) + r;
		for (int i = x0; i <= x1; i++) begin
			for (int j = y0; j <= y1; j++) begin
				dx = cx - 16 * i;
				dy = cy - 16 * j;
				d = int_sqrt(dx * dx + dy * dy);
				e = 16 * peak - int'(d) * fall;
				v = e < 0 ? 0 : e / 16;
				if (v > 255)
					v = 255;
				put_pixel(i, j, {hue, sat, 8'(v)});
			end
		end
	endfunction

	// applies one command to the shadow store and returns its response
	function automatic pixel_resp_t draw_and_respond(draw_cmd_t c);
		pixel_resp_t rsp;
		int x, y, w, h, hh, idx;
		logic [23:0] hsv;
		x = int'($signed(c.pos_x));
		y = int'($signed(c.pos_y));
		w = int'(c.rect_w);
		h = int'(c.rect_h);
		hsv = {c.hue, c.sat, c.val};
		rsp = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
		case (c.cmd)
			CMD_DOT: put_pixel(x, y, hsv);
			CMD_OUTLINE: begin
				for (int i = x; i < x + w; i++) begin
					put_pixel(i, y, hsv);
					put_pixel(i, y + h, hsv);
				end
				for (int j = y; j <= y + h; j++) begin
					put_pixel(x, j, hsv);
					put_pixel(x + w, j, hsv);
				end
			end
			CMD_FILL: begin
				for (int i = x; i < x + w; i++)
					for (int j = y; j < y + h; j++)
						put_pixel(i, j, hsv);
			end
			CMD_GLOW: draw_glow(x * 16 + int'(c.frac_x), y * 16 + int'(c.frac_y),
				int'(c.radius), int'(c.falloff), c.hue, c.sat, int'(c.val));
			CMD_READ: begin
				if (on_grid(x, y)) begin
					// serpentine: even rows run backward, row length is the height
					hh = eff_h();
					idx = (y % 2 == 0) ? (hh - 1 - x) + y * hh : x + y * hh;
					rsp.led_index = 8'(idx);
					{rsp.hue, rsp.sat, rsp.val} = shadow_px[x][y];
				end else begin
					rsp.in_range = 1'b0;
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	// sender side: offer the next queued command at the falling edge; also drive m_tready at random
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || cmd_took)) begin
			if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				cmd_on_bus = cmd_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= pack_cmd(cmd_on_bus);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
	end

	// input transfer: predict; output transfer: check against oldest prediction
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_matrix_draw_engine: mismatch");
			$finish;
		end
		cmd_took = s_tvalid && s_tready;
		if (cmd_took)
			resp_q.push_back(draw_and_respond(cmd_on_bus));
		if (m_tvalid && m_tready) begin
			if (resp_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				pixel_resp_t want;
				want = resp_q.pop_front();
				if (m_tdata[7:0] !== want.led_index || m_tdata[15:8] !== want.hue ||
						m_tdata[23:16] !== want.sat || m_tdata[31:24] !== want.val ||
						m_tdata[32] !== want.in_range) begin
					$display({"%0t: result differs: expected idx %h hsv %h%h%h in %b,",
						" actual idx %h hsv %h in %b"},
						$time, want.led_index, want.hue, want.sat, want.val,
						want.in_range, m_tdata[7:0], {m_tdata[15:8], m_tdata[23:16],
						m_tdata[31:24]}, m_tdata[32]);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(logic [2:0] addr, int value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_ADDR_WIDTH)
			grid_w_reg = value & 31;
		else
			grid_h_reg = value & 31;
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || s_tvalid || resp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_grid(int w, int h);
		wait_drained();
		reg_write(REG_ADDR_WIDTH, w);
		reg_write(REG_ADDR_HEIGHT, h);
	endtask

	function automatic draw_cmd_t mk(logic [2:0] op, int x, int y, int w = 0, int h = 0,
			logic [7:0] hue = 8'h00, logic [7:0] sat = 8'h00, logic [7:0] val = 8'h00);
		draw_cmd_t c;
		c = '{op, 6'(x), 6'(y), 4'd0, 4'd0, 5'(w), 5'(h), 4'd0, 8'd0, hue, sat, val};
		return c;
	endfunction

	// random command: mostly near the grid with small shapes, rarely anything
	function automatic draw_cmd_t rand_cmd();
		draw_cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c.cmd = pick < 30 ? CMD_READ : pick < 52 ? CMD_DOT : pick < 67 ? CMD_FILL :
			pick < 82 ? CMD_OUTLINE : pick < 95 ? CMD_GLOW :
			3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		c.pos_x = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(19) - 2);
		c.pos_y = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(19) - 2);
		c.frac_x = 4'($urandom);
		c.frac_y = 4'($urandom);
		c.rect_w = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(6));
		c.rect_h = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(6));
		c.radius = ($urandom_range(49) == 0) ? 4'($urandom) : 4'($urandom_range(3));
		c.falloff = 8'($urandom);
		c.hue = 8'($urandom);
		c.sat = 8'($urandom);
		c.val = 8'($urandom);
		return c;
	endfunction

	initial begin
		int grid_sets [8][2];
		draw_cmd_t g;
		grid_sets = '{'{16, 16}, '{1, 1}, '{31, 31}, '{0, 5}, '{7, 12},
			'{16, 3}, '{5, 0}, '{12, 16}};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_took = 1'b0;
		errors = 0;
		cycles = 0;
		grid_w_reg = 16;
		grid_h_reg = 16;
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++)
				shadow_px[i][j] = '0;
		src_idle_pct = 14;
		snk_idle_pct = 50;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, clipping, every defined opcode and two spare codes, degenerate shapes
		cmd_q.push_back(mk(CMD_READ, 3, 4));
		cmd_q.push_back(mk(CMD_DOT, 0, 0, 0, 0, 8'hff, 8'hff, 8'hff));
		cmd_q.push_back(mk(CMD_DOT, 15, 15, 0, 0, 8'h5a, 8'ha5, 8'h3c));
		cmd_q.push_back(mk(CMD_DOT, -32, -32, 0, 0, 8'h11, 8'h22, 8'h33));
		cmd_q.push_back(mk(CMD_DOT, 31, 31, 0, 0, 8'h11, 8'h22, 8'h33));
		cmd_q.push_back(mk(CMD_READ, 0, 0));
		cmd_q.push_back(mk(CMD_READ, 15, 15));
		cmd_q.push_back(mk(CMD_READ, -32, 0));
		cmd_q.push_back(mk(CMD_READ, 31, 31));
		cmd_q.push_back(mk(CMD_OUTLINE, 2, 2, 0, 4, 8'h01, 8'h02, 8'h03));
		cmd_q.push_back(mk(CMD_OUTLINE, -3, -3, 31, 31, 8'h80, 8'h40, 8'h20));
		cmd_q.push_back(mk(CMD_FILL, 0, 0, 31, 31, 8'h0f, 8'hf0, 8'h77));
		cmd_q.push_back(mk(CMD_FILL, 4, 4, 0, 6, 8'hee, 8'hee, 8'hee));
		cmd_q.push_back(mk(CMD_READ, 2, 3));
		g = mk(CMD_GLOW, 7, 8, 0, 0, 8'haa, 8'h55, 8'hff);
		g.frac_x = 4'hf;
		g.frac_y = 4'hf;
		g.radius = 4'hf;
		g.falloff = 8'hff;
		cmd_q.push_back(g);
		g = mk(CMD_GLOW, -1, 0, 0, 0, 8'h12, 8'h34, 8'hff);
		g.radius = 4'd3;
		cmd_q.push_back(g);
		cmd_q.push_back(mk(CMD_READ, 0, 1));
		cmd_q.push_back(mk(CMD_READ, 7, 8));
		cmd_q.push_back(mk(CMD_SPARE_LO, 1, 1, 1, 1, 8'h99, 8'h99, 8'h99));
		cmd_q.push_back(mk(CMD_SPARE_HI, 1, 1, 1, 1, 8'h99, 8'h99, 8'h99));
		cmd_q.push_back(mk(CMD_READ, 1, 1));

		// three idling regimes, each sweeping several grid sizes
		for (int ph = 0; ph < 3; ph++) begin
			for (int s = 0; s < 8; s++) begin
				set_grid(grid_sets[(s + 3 * ph) % 8][0], grid_sets[(s + 3 * ph) % 8][1]);
				src_idle_pct = ph == 0 ? 14 : ph == 1 ? 50 : 0;
				snk_idle_pct = ph == 0 ? 50 : ph == 1 ? 14 : 0;
				for (int n = 0; n < RAND_ITEMS / 24; n++)
					cmd_q.push_back(rand_cmd());
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("led_matrix_draw_engine: match");
		else
			$display("led_matrix_draw_engine: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/lmd_pkg.sv
src/lmd_front.sv
src/lmd_back.sv
src/led_matrix_draw_engine.sv
tb/tb_top.sv
